@@ hw/rtl/bct_pkg.sv @@
// Shared codes and widths for the brew controller with timed pour.
`default_nettype none

package bct_pkg;

   // Field widths.
   localparam int unsigned OP_W      = 4;
   localparam int unsigned SEC_W     = 10;
   localparam int unsigned TOGGLE_W  = 2;
   localparam int unsigned TEMP_W    = 2;
   localparam int unsigned CMD_W     = 3;
   localparam int unsigned TPS_W     = 10;
   localparam int unsigned TICKS_W   = 20;

   // Ticks-per-second register limits.
   localparam logic [TPS_W-1:0] TPS_MIN   = 10'd1;
   localparam logic [TPS_W-1:0] TPS_MAX   = 10'd1000;
   localparam logic [TPS_W-1:0] TPS_RESET = 10'd1000;

   // Input operation codes.
   localparam logic [OP_W-1:0] OP_TICK  = 4'd0;
   localparam logic [OP_W-1:0] OP_OFF   = 4'd1;
   localparam logic [OP_W-1:0] OP_POUR  = 4'd2;
   localparam logic [OP_W-1:0] OP_STOP  = 4'd3;
   localparam logic [OP_W-1:0] OP_COOL  = 4'd4;
   localparam logic [OP_W-1:0] OP_BOIL  = 4'd5;
   localparam logic [OP_W-1:0] OP_STEAM = 4'd6;
   localparam logic [OP_W-1:0] OP_BREW  = 4'd7;
   localparam logic [OP_W-1:0] OP_QUERY = 4'd8;

   // Active command codes.
   localparam logic [CMD_W-1:0] CMD_OFF   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POUR  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_COOL  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_BOIL  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_STEAM = 3'd5;
   localparam logic [CMD_W-1:0] CMD_BREW  = 3'd6;

   // Boiler temperature classes, sensed and targeted.
   localparam logic [TEMP_W-1:0] TEMP_COLD  = 2'd0;
   localparam logic [TEMP_W-1:0] TEMP_BOIL  = 2'd1;
   localparam logic [TEMP_W-1:0] TEMP_STEAM = 2'd2;

   // Panel toggle positions.
   localparam logic [TOGGLE_W-1:0] TGL_OFF   = 2'd0;
   localparam logic [TOGGLE_W-1:0] TGL_BOIL  = 2'd1;
   localparam logic [TOGGLE_W-1:0] TGL_STEAM = 2'd2;
   localparam logic [TOGGLE_W-1:0] TGL_POUR  = 2'd3;

endpackage

`default_nettype wire

@@ hw/rtl/brew_controller_with_timed_pour.sv @@
// Top level of the brew controller: command decode, timed pour and result register.
`default_nettype none

// The block takes one item (tick, panel command or done query) per clock and
// returns exactly one result for it, registered in the cycle after the input transfer. All
// work for an item is a single pass of short logic from the held controller
// state into the result register, so a new item is taken every cycle while the
// result side keeps up; req_stall rises only when the result register is full
// and rsp_stall holds it. The brew length is seconds times ticks_per_second from
// one 10 by 10 bit multiplier in that pass. There is no start-up sweep: the
// block is ready in the first cycle after reset. Write ticks_per_second only
// while no item is in flight.
module brew_controller_with_timed_pour #(
   parameter int unsigned MAX_SECONDS = 1023
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Input channel
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [bct_pkg::OP_W-1:0]        req_op,
   input  wire logic [bct_pkg::SEC_W-1:0]       req_seconds,
   input  wire logic [bct_pkg::TOGGLE_W-1:0]    req_toggle_position,
   input  wire logic                            req_toggled,
   input  wire logic [bct_pkg::TEMP_W-1:0]      req_boiler_temp,
   // Result channel
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic                            rsp_pump_on,
   output      logic [bct_pkg::TEMP_W-1:0]      rsp_target_temp,
   output      logic                            rsp_accepted,
   output      logic                            rsp_done_led,
   output      logic                            rsp_done_reported,
   output      logic [bct_pkg::TICKS_W-1:0]     rsp_time_left,
   output      logic [bct_pkg::CMD_W-1:0]       rsp_active_command,
   // Configuration port
   input  wire logic                            csr_wr_en,
   input  wire logic [bct_pkg::TPS_W-1:0]       csr_wr_data
);

   import bct_pkg::*;

   // Largest brew length in seconds that the seconds field can carry.
   localparam int unsigned SecFieldMax = (1 << SEC_W) - 1;
   localparam int unsigned SecCapInt   = (MAX_SECONDS > SecFieldMax) ? SecFieldMax
                                                                    : MAX_SECONDS;
   localparam logic [SEC_W-1:0] SecCap = SEC_W'(SecCapInt);

   // Controller state
   logic [CMD_W-1:0]   cmd_ff,   cmd_in;
   logic               pump_ff,  pump_in;
   logic [TEMP_W-1:0]  tgt_ff,   tgt_in;
   logic [TICKS_W-1:0] rem_ff,   rem_in;
   logic               pour_ff,  pour_in;
   logic               done_ff,  done_in;
   logic [TPS_W-1:0]   tps_ff,   tps_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_pump_ff;
   logic [TEMP_W-1:0]  rsp_tgt_ff;
   logic               rsp_acc_ff;
   logic               rsp_led_ff;
   logic               rsp_rep_ff;
   logic [TICKS_W-1:0] rsp_rem_ff;
   logic [CMD_W-1:0]   rsp_cmd_ff;

   logic               in_xfer;
   logic               acc_in;
   logic               rep_in;
   logic [SEC_W-1:0]   secs_sat;
   logic [TICKS_W-1:0] brew_ticks;
   logic [TICKS_W-1:0] rem_dec;

   // An input transfer happens unless a full result register is held.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign in_xfer   = req_valid & ~req_stall;

   // Brew length in ticks; 1023 * 1000 still fits in twenty bits.
   assign secs_sat   = (req_seconds > SecCap) ? SecCap : req_seconds;
   assign brew_ticks = {{(TICKS_W-SEC_W){1'b0}}, secs_sat}
                     * {{(TICKS_W-TPS_W){1'b0}}, tps_ff};

   // Configuration write, clamped into the supported range.
   always_comb begin
      tps_in = tps_ff;
      if (csr_wr_en) begin
         if (csr_wr_data < TPS_MIN) begin
            tps_in = TPS_MIN;
         end else if (csr_wr_data > TPS_MAX) begin
            tps_in = TPS_MAX;
         end else begin
            tps_in = csr_wr_data;
         end
      end
   end

   // Next controller state and result flags for the item at the input.
   always_comb begin
      cmd_in  = cmd_ff;
      pump_in = pump_ff;
      tgt_in  = tgt_ff;
      rem_in  = rem_ff;
      pour_in = pour_ff;
      done_in = done_ff;
      acc_in  = 1'b0;
      rep_in  = 1'b0;
      rem_dec = rem_ff - TICKS_W'(1);

      unique case (req_op) inside
         OP_TICK: begin
            // A moved toggle acts as the matching panel command.
            if (req_toggled) begin
               rem_in  = '0;
               pour_in = 1'b0;
               unique case (req_toggle_position)
                  TGL_BOIL: begin
                     pump_in = 1'b0;
                     tgt_in  = TEMP_BOIL;
                     cmd_in  = CMD_BOIL;
                  end
                  TGL_STEAM: begin
                     pump_in = 1'b0;
                     tgt_in  = TEMP_STEAM;
                     cmd_in  = CMD_STEAM;
                  end
                  TGL_POUR: begin
                     pump_in = 1'b1;
                     tgt_in  = TEMP_COLD;
                     cmd_in  = CMD_POUR;
                  end
                  default: begin
                     pump_in = 1'b0;
                     tgt_in  = TEMP_COLD;
                     cmd_in  = CMD_OFF;
                  end
               endcase
            end
            // Timed pour: count down while pouring, resume when boiling.
            if (rem_in != '0) begin
               if (pour_in) begin
                  rem_in = rem_dec;
                  if (rem_dec == '0) begin
                     pump_in = 1'b0;
                     tgt_in  = TEMP_COLD;
                     pour_in = 1'b0;
                  end else if (req_boiler_temp != TEMP_BOIL) begin
                     pump_in = 1'b0;
                     pour_in = 1'b0;
                  end
               end else if (req_boiler_temp == TEMP_BOIL) begin
                  pump_in = 1'b1;
                  pour_in = 1'b1;
               end
            end
            // Done indicator is refreshed on every tick.
            if (cmd_in == CMD_BREW) begin
               done_in = (rem_in == '0);
            end else begin
               done_in = (tgt_in != TEMP_COLD) && (req_boiler_temp == tgt_in);
            end
         end
         OP_OFF, OP_POUR, OP_STOP, OP_COOL, OP_BOIL, OP_STEAM: begin
            // Plain commands are taken only with the toggle off.
            if (req_toggle_position == TGL_OFF) begin
               acc_in  = 1'b1;
               rem_in  = '0;
               pour_in = 1'b0;
               cmd_in  = CMD_W'(req_op - OP_OFF);
               case (req_op)
                  OP_OFF: begin
                     pump_in = 1'b0;
                     tgt_in  = TEMP_COLD;
                  end
                  OP_POUR:  pump_in = 1'b1;
                  OP_STOP:  pump_in = 1'b0;
                  OP_COOL:  tgt_in  = TEMP_COLD;
                  OP_BOIL:  tgt_in  = TEMP_BOIL;
                  default:  tgt_in  = TEMP_STEAM;
               endcase
            end
         end
         OP_BREW: begin
            // A brew needs the toggle off and a nonzero length.
            if ((req_toggle_position == TGL_OFF) && (req_seconds != '0)) begin
               acc_in  = 1'b1;
               pump_in = 1'b0;
               tgt_in  = TEMP_BOIL;
               rem_in  = brew_ticks;
               pour_in = 1'b0;
               cmd_in  = CMD_BREW;
            end
         end
         OP_QUERY: begin
            // A finished brew reports once and may switch the block off.
            if ((cmd_ff == CMD_BREW) && done_ff) begin
               if (req_toggle_position == TGL_OFF) begin
                  pump_in = 1'b0;
                  tgt_in  = TEMP_COLD;
                  cmd_in  = CMD_OFF;
                  rem_in  = '0;
                  pour_in = 1'b0;
               end
               done_in = 1'b0;
               rep_in  = 1'b1;
            end else begin
               rep_in = done_ff;
            end
         end
         default: begin
            // Unused operation codes leave the state alone.
         end
      endcase
   end

   // Result valid: set by an input transfer, cleared when the result is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (in_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state and configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= CMD_OFF;
         pump_ff      <= 1'b0;
         tgt_ff       <= TEMP_COLD;
         rem_ff       <= '0;
         pour_ff      <= 1'b0;
         done_ff      <= 1'b0;
         tps_ff       <= TPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tps_ff       <= tps_in;
         rsp_valid_ff <= rsp_valid_in;
         if (in_xfer) begin
            cmd_ff  <= cmd_in;
            pump_ff <= pump_in;
            tgt_ff  <= tgt_in;
            rem_ff  <= rem_in;
            pour_ff <= pour_in;
            done_ff <= done_in;
         end
      end
   end

   // Result payload, loaded on each input transfer.
   always_ff @(posedge clock) begin
      if (in_xfer) begin
         rsp_pump_ff <= pump_in;
         rsp_tgt_ff  <= tgt_in;
         rsp_acc_ff  <= acc_in;
         rsp_led_ff  <= done_in;
         rsp_rep_ff  <= rep_in;
         rsp_rem_ff  <= rem_in;
         rsp_cmd_ff  <= cmd_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pump_on        = rsp_pump_ff;
   assign rsp_target_temp    = rsp_tgt_ff;
   assign rsp_accepted       = rsp_acc_ff;
   assign rsp_done_led       = rsp_led_ff;
   assign rsp_done_reported  = rsp_rep_ff;
   assign rsp_time_left      = rsp_rem_ff;
   assign rsp_active_command = rsp_cmd_ff;

endmodule

`default_nettype wire

@@ hw/rtl/bct_checker.sv @@
// Port-level checks for the brew controller, bound to its top level.
`default_nettype none

module bct_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic                            rsp_pump_on,
   input wire logic [bct_pkg::TEMP_W-1:0]      rsp_target_temp,
   input wire logic                            rsp_accepted,
   input wire logic                            rsp_done_led,
   input wire logic                            rsp_done_reported,
   input wire logic [bct_pkg::TICKS_W-1:0]     rsp_time_left,
   input wire logic [bct_pkg::CMD_W-1:0]       rsp_active_command
);

   import bct_pkg::*;

   // A held result stays offered.
   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result valid dropped while stalled");

   // A held result keeps its payload.
   a_payload_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_time_left) && $stable(rsp_pump_on)
         && $stable(rsp_target_temp) && $stable(rsp_active_command)
         && $stable(rsp_accepted) && $stable(rsp_done_led)
         && $stable(rsp_done_reported))
      else $error("result payload changed while stalled");

   // Remaining brew time exists only during a brew.
   a_time_only_in_brew: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_active_command != CMD_BREW) |-> (rsp_time_left == '0))
      else $error("time left outside a brew");

   // The pump never runs in a brew whose time has run out.
   a_brew_pump_has_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pump_on && (rsp_active_command == CMD_BREW)
         |-> (rsp_time_left != '0))
      else $error("pump on in a finished brew");

   // A command acceptance and a query answer never share one transfer.
   a_accept_or_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_done_reported))
      else $error("accepted and done reported together");

endmodule

bind brew_controller_with_timed_pour bct_checker u_bct_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_pump_on        (rsp_pump_on),
   .rsp_target_temp    (rsp_target_temp),
   .rsp_accepted       (rsp_accepted),
   .rsp_done_led       (rsp_done_led),
   .rsp_done_reported  (rsp_done_reported),
   .rsp_time_left      (rsp_time_left),
   .rsp_active_command (rsp_active_command)
);

`default_nettype wire
